// ===== rtl/amt_pkg.sv =====
// Shared types and constants for the transformed bounding box block.
`default_nettype none
package amt_pkg;

  localparam int FIELD_W     = 32;
  localparam int MAT_W       = 32;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 4;
  localparam int NUM_REGS    = 8;
  localparam int NUM_AXES    = 3;
  localparam int NUM_COLS    = 4;
  // Headroom above the coordinate width for three products plus the translation term.
  localparam int ACC_GUARD   = 34;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R1_C12 = 4'd0,
    REG_R1_C34 = 4'd1,
    REG_R2_C12 = 4'd2,
    REG_R2_C34 = 4'd3,
    REG_R3_C12 = 4'd4,
    REG_R3_C34 = 4'd5,
    REG_R4_C12 = 4'd6,
    REG_R4_C34 = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] in_min_x;
    logic signed [FIELD_W-1:0] in_min_y;
    logic signed [FIELD_W-1:0] in_min_z;
    logic signed [FIELD_W-1:0] in_max_x;
    logic signed [FIELD_W-1:0] in_max_y;
    logic signed [FIELD_W-1:0] in_max_z;
  } box_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_min_x;
    logic signed [FIELD_W-1:0] out_min_y;
    logic signed [FIELD_W-1:0] out_min_z;
    logic signed [FIELD_W-1:0] out_max_x;
    logic signed [FIELD_W-1:0] out_max_y;
    logic signed [FIELD_W-1:0] out_max_z;
    logic                      divide_fault;
  } res_t;

  typedef struct packed {
    logic last;
    logic skip;
  } corner_tag_t;

endpackage
`default_nettype wire

// ===== rtl/amt_if.sv =====
// Handshake channels for source boxes and transformed boxes.
`default_nettype none
interface amt_box_if;
  logic          valid;
  logic          ready;
  amt_pkg::box_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface amt_res_if;
  logic          valid;
  logic          ready;
  amt_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/amt_box_queue.sv =====
// Front end: accepts boxes, sizes coordinates to COORD_BITS, holds them in a two-entry queue.
`default_nettype none
module amt_box_queue #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push_valid,
  output logic                              push_ready,
  input  wire amt_pkg::box_t                push_data,
  output logic                              head_valid,
  input  wire logic                         pop,
  output logic signed [COORD_BITS-1:0]      head_lo [amt_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0]      head_hi [amt_pkg::NUM_AXES]
);

  localparam int EW = 2 * amt_pkg::NUM_AXES * COORD_BITS;

  logic [EW-1:0] mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic [EW-1:0] entry;
  logic [EW-1:0] head;
  logic          push;

  function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [31:0] f);
    logic signed [63:0] e;
    e = {{32{f[31]}}, f};
    return e[COORD_BITS-1:0];
  endfunction

  assign entry = {to_coord(push_data.in_max_z), to_coord(push_data.in_max_y),
                  to_coord(push_data.in_max_x), to_coord(push_data.in_min_z),
                  to_coord(push_data.in_min_y), to_coord(push_data.in_min_x)};

  assign push_ready = (count_r != 2'd2);
  assign push       = push_valid && push_ready;
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    for (int j = 0; j < amt_pkg::NUM_AXES; j++) begin
      head_lo[j] = head[j*COORD_BITS +: COORD_BITS];
      head_hi[j] = head[(j+amt_pkg::NUM_AXES)*COORD_BITS +: COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/amt_xform.sv =====
// Corner transform: products, row sums, then magnitudes and signs for the divider.
`default_nettype none
module amt_xform #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              issue_valid,
  input  wire amt_pkg::corner_tag_t              issue_tag,
  input  wire logic signed [COORD_BITS-1:0]      point [amt_pkg::NUM_AXES],
  input  wire logic [amt_pkg::CFG_W-1:0]         mat [amt_pkg::NUM_REGS],
  output logic                                   out_valid,
  output amt_pkg::corner_tag_t                   out_tag,
  output logic [COORD_BITS+amt_pkg::ACC_GUARD+COORD_BITS+FRAC_BITS:0] num [amt_pkg::NUM_AXES],
  output logic                                   neg [amt_pkg::NUM_AXES],
  output logic [COORD_BITS+amt_pkg::ACC_GUARD-1:0] den
);

  localparam int PW    = COORD_BITS + amt_pkg::MAT_W;
  localparam int ACC_W = COORD_BITS + amt_pkg::ACC_GUARD;
  localparam int RW    = ACC_W + COORD_BITS + FRAC_BITS + 1;

  logic signed [PW-1:0]    prod_r [amt_pkg::NUM_AXES][amt_pkg::NUM_COLS];
  logic signed [ACC_W-1:0] acc_r [amt_pkg::NUM_COLS];
  logic                    v1_r, v2_r, v3_r;
  amt_pkg::corner_tag_t    tag1_r, tag2_r, tag3_r;
  logic [RW-1:0]           num_r [amt_pkg::NUM_AXES];
  logic                    neg_r [amt_pkg::NUM_AXES];
  logic [ACC_W-1:0]        den_r;
  logic [ACC_W-1:0]        mag [amt_pkg::NUM_AXES];
  logic [ACC_W-1:0]        wmag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= issue_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Products of the point with the upper three matrix rows.
  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r <= issue_tag;
      for (int r = 0; r < amt_pkg::NUM_AXES; r++) begin
        for (int j = 0; j < amt_pkg::NUM_COLS; j++) begin
          prod_r[r][j] <= point[r] * $signed(mat[3'(r*2 + j/2)][(j%2)*32 +: 32]);
        end
      end
    end
  end

  // Row sums; the translation row is scaled up to the product's fraction.
  always_ff @(posedge clk) begin
    if (en) begin
      tag2_r <= tag1_r;
      for (int j = 0; j < amt_pkg::NUM_COLS; j++) begin
        acc_r[j] <= ACC_W'(prod_r[0][j]) + ACC_W'(prod_r[1][j]) + ACC_W'(prod_r[2][j])
                  + (ACC_W'($signed(mat[3'(6 + j/2)][(j%2)*32 +: 32])) <<< FRAC_BITS);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < amt_pkg::NUM_AXES; j++) begin
      mag[j] = acc_r[j][ACC_W-1] ? ACC_W'(-acc_r[j]) : ACC_W'(acc_r[j]);
    end
    wmag = acc_r[3][ACC_W-1] ? ACC_W'(-acc_r[3]) : ACC_W'(acc_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3_r.last <= tag2_r.last;
      tag3_r.skip <= (acc_r[3] == '0);
      den_r       <= wmag;
      for (int j = 0; j < amt_pkg::NUM_AXES; j++) begin
        num_r[j] <= RW'(mag[j]) << FRAC_BITS;
        neg_r[j] <= acc_r[j][ACC_W-1] ^ acc_r[3][ACC_W-1];
      end
    end
  end

  assign out_valid = v3_r;
  assign out_tag   = tag3_r;
  assign num       = num_r;
  assign neg       = neg_r;
  assign den       = den_r;

endmodule
`default_nettype wire

// ===== rtl/amt_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
`default_nettype none
module amt_div #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire amt_pkg::corner_tag_t              in_tag,
  input  wire logic [COORD_BITS+amt_pkg::ACC_GUARD+COORD_BITS+FRAC_BITS:0] num [amt_pkg::NUM_AXES],
  input  wire logic                              neg [amt_pkg::NUM_AXES],
  input  wire logic [COORD_BITS+amt_pkg::ACC_GUARD-1:0] den,
  output logic                                   out_valid,
  output amt_pkg::corner_tag_t                   out_tag,
  output logic [COORD_BITS-1:0]                  quo [amt_pkg::NUM_AXES],
  output logic                                   ovf [amt_pkg::NUM_AXES],
  output logic                                   qneg [amt_pkg::NUM_AXES]
);

  localparam int ACC_W = COORD_BITS + amt_pkg::ACC_GUARD;
  localparam int RW    = ACC_W + COORD_BITS + FRAC_BITS + 1;
  localparam int NS    = COORD_BITS + 1;

  logic                    v_r   [NS];
  amt_pkg::corner_tag_t    tag_r [NS];
  logic [ACC_W-1:0]        den_r [NS];
  logic [RW-1:0]           rem_r [NS][amt_pkg::NUM_AXES];
  logic [COORD_BITS-1:0]   quo_r [NS][amt_pkg::NUM_AXES];
  logic                    ovf_r [NS][amt_pkg::NUM_AXES];
  logic                    neg_r [NS][amt_pkg::NUM_AXES];

  // First stage: a quotient of 2^COORD_BITS or more can only saturate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      den_r[0] <= den;
      for (int l = 0; l < amt_pkg::NUM_AXES; l++) begin
        rem_r[0][l] <= num[l];
        quo_r[0][l] <= '0;
        ovf_r[0][l] <= (num[l] >= (RW'(den) << COORD_BITS));
        neg_r[0][l] <= neg[l];
      end
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    localparam int B = COORD_BITS - s;
    logic [RW-1:0]         rem_nxt [amt_pkg::NUM_AXES];
    logic [COORD_BITS-1:0] quo_nxt [amt_pkg::NUM_AXES];
    logic [RW-1:0]         shifted;

    always_comb begin
      shifted = RW'(den_r[s-1]) << B;
      for (int l = 0; l < amt_pkg::NUM_AXES; l++) begin
        quo_nxt[l] = quo_r[s-1][l];
        if (rem_r[s-1][l] >= shifted) begin
          rem_nxt[l]    = rem_r[s-1][l] - shifted;
          quo_nxt[l][B] = 1'b1;
        end else begin
          rem_nxt[l] = rem_r[s-1][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[s] <= tag_r[s-1];
        den_r[s] <= den_r[s-1];
        for (int l = 0; l < amt_pkg::NUM_AXES; l++) begin
          rem_r[s][l] <= rem_nxt[l];
          quo_r[s][l] <= quo_nxt[l];
          ovf_r[s][l] <= ovf_r[s-1][l];
          neg_r[s][l] <= neg_r[s-1][l];
        end
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_tag   = tag_r[NS-1];
  assign quo       = quo_r[NS-1];
  assign ovf       = ovf_r[NS-1];
  assign qneg      = neg_r[NS-1];

endmodule
`default_nettype wire

// ===== rtl/amt_reduce.sv =====
// Back end tail: saturation, per-axis min and max over a box's corners, and the result register.
`default_nettype none
module amt_reduce #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  output logic                             en,
  input  wire logic                        in_valid,
  input  wire amt_pkg::corner_tag_t        in_tag,
  input  wire logic [COORD_BITS-1:0]       quo [amt_pkg::NUM_AXES],
  input  wire logic                        ovf [amt_pkg::NUM_AXES],
  input  wire logic                        qneg [amt_pkg::NUM_AXES],
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output amt_pkg::res_t                    res_data
);

  localparam logic signed [COORD_BITS-1:0] SMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] SMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic                          any_r, fault_r, res_valid_r;
  logic signed [COORD_BITS-1:0]  mn_r [amt_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0]  mx_r [amt_pkg::NUM_AXES];
  amt_pkg::res_t                 res_r;
  logic signed [COORD_BITS-1:0]  val [amt_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0]  mn_nxt [amt_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0]  mx_nxt [amt_pkg::NUM_AXES];
  logic                          keep, any_nxt, fault_nxt;
  logic [31:0]                   fmn [amt_pkg::NUM_AXES];
  logic [31:0]                   fmx [amt_pkg::NUM_AXES];

  function automatic logic [31:0] to_field(input logic signed [COORD_BITS-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[31:0];
  endfunction

  assign en        = !res_valid_r || res_ready;
  assign keep      = in_valid && !in_tag.skip;
  assign any_nxt   = any_r || keep;
  assign fault_nxt = fault_r || (in_valid && in_tag.skip);

  always_comb begin
    for (int l = 0; l < amt_pkg::NUM_AXES; l++) begin
      if (qneg[l]) begin
        val[l] = (ovf[l] || (quo[l] > {1'b1, {(COORD_BITS-1){1'b0}}}))
               ? SMIN : COORD_BITS'(-$signed(quo[l]));
      end else begin
        val[l] = (ovf[l] || quo[l][COORD_BITS-1]) ? SMAX : $signed(quo[l]);
      end
      mn_nxt[l] = (keep && (!any_r || (val[l] < mn_r[l]))) ? val[l] : mn_r[l];
      mx_nxt[l] = (keep && (!any_r || (mx_r[l] < val[l]))) ? val[l] : mx_r[l];
      fmn[l]    = any_nxt ? to_field(mn_nxt[l]) : '0;
      fmx[l]    = any_nxt ? to_field(mx_nxt[l]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r       <= 1'b0;
      fault_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_ready) begin
        res_valid_r <= 1'b0;
      end
      if (en && in_valid) begin
        if (in_tag.last) begin
          any_r       <= 1'b0;
          fault_r     <= 1'b0;
          res_valid_r <= 1'b1;
        end else begin
          any_r   <= any_nxt;
          fault_r <= fault_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      mn_r <= mn_nxt;
      mx_r <= mx_nxt;
      if (in_tag.last) begin
        res_r.out_min_x    <= fmn[0];
        res_r.out_min_y    <= fmn[1];
        res_r.out_min_z    <= fmn[2];
        res_r.out_max_x    <= fmx[0];
        res_r.out_max_y    <= fmx[1];
        res_r.out_max_z    <= fmx[2];
        res_r.divide_fault <= fault_nxt;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res_data  = res_r;

endmodule
`default_nettype wire

// ===== rtl/aabb_matrix_transform_core.sv =====
// Top level: matrix registers, corner sequencer and the transform pipeline.
// Each box is issued as eight corners; the transform and divider take one corner per cycle
// except while the result register is full and not taken, which holds the whole pipeline.
// Up to two boxes wait in the front queue while the back end works or stalls.
// Reset (synchronous, rst_n low) loads the identity matrix and empties the pipeline.
`default_nettype none
module aabb_matrix_transform_core #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  amt_box_if.sink                            in_box,
  amt_res_if.source                          out_res,
  input  wire logic                          cfg_we,
  input  wire logic [amt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [amt_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int ACC_W = COORD_BITS + amt_pkg::ACC_GUARD;
  localparam int RW    = ACC_W + COORD_BITS + FRAC_BITS + 1;
  localparam logic [amt_pkg::CFG_W-1:0] ONE_LO = amt_pkg::CFG_W'(1) << FRAC_BITS;
  localparam logic [amt_pkg::CFG_W-1:0] ONE_HI = amt_pkg::CFG_W'(1) << (FRAC_BITS + 32);

  logic [amt_pkg::CFG_W-1:0]     mat_r [amt_pkg::NUM_REGS];
  logic [2:0]                    corner_r;
  logic                          en;
  logic                          q_valid, q_pop;
  logic signed [COORD_BITS-1:0]  q_lo [amt_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0]  q_hi [amt_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0]  point [amt_pkg::NUM_AXES];
  amt_pkg::corner_tag_t          issue_tag;
  logic                          x_valid;
  amt_pkg::corner_tag_t          x_tag;
  logic [RW-1:0]                 x_num [amt_pkg::NUM_AXES];
  logic                          x_neg [amt_pkg::NUM_AXES];
  logic [ACC_W-1:0]              x_den;
  logic                          d_valid;
  amt_pkg::corner_tag_t          d_tag;
  logic [COORD_BITS-1:0]         d_quo [amt_pkg::NUM_AXES];
  logic                          d_ovf [amt_pkg::NUM_AXES];
  logic                          d_neg [amt_pkg::NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= ONE_LO;
      mat_r[1] <= '0;
      mat_r[2] <= ONE_HI;
      mat_r[3] <= '0;
      mat_r[4] <= '0;
      mat_r[5] <= ONE_LO;
      mat_r[6] <= '0;
      mat_r[7] <= ONE_HI;
    end else if (cfg_we) begin
      case (cfg_idx)
        amt_pkg::REG_R1_C12: mat_r[0] <= cfg_wdata;
        amt_pkg::REG_R1_C34: mat_r[1] <= cfg_wdata;
        amt_pkg::REG_R2_C12: mat_r[2] <= cfg_wdata;
        amt_pkg::REG_R2_C34: mat_r[3] <= cfg_wdata;
        amt_pkg::REG_R3_C12: mat_r[4] <= cfg_wdata;
        amt_pkg::REG_R3_C34: mat_r[5] <= cfg_wdata;
        amt_pkg::REG_R4_C12: mat_r[6] <= cfg_wdata;
        amt_pkg::REG_R4_C34: mat_r[7] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  amt_box_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_box.valid),
    .push_ready (in_box.ready),
    .push_data  (in_box.data),
    .head_valid (q_valid),
    .pop        (q_pop),
    .head_lo    (q_lo),
    .head_hi    (q_hi)
  );

  // Corner c takes the max coordinate on axis j when bit j of c is set.
  assign q_pop           = en && q_valid && (corner_r == 3'd7);
  assign issue_tag.last  = (corner_r == 3'd7);
  assign issue_tag.skip  = 1'b0;

  always_comb begin
    for (int j = 0; j < amt_pkg::NUM_AXES; j++) begin
      point[j] = corner_r[j] ? q_hi[j] : q_lo[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= 3'd0;
    end else if (en && q_valid) begin
      corner_r <= corner_r + 3'd1;
    end
  end

  amt_xform #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_xform (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .issue_valid (q_valid),
    .issue_tag   (issue_tag),
    .point       (point),
    .mat         (mat_r),
    .out_valid   (x_valid),
    .out_tag     (x_tag),
    .num         (x_num),
    .neg         (x_neg),
    .den         (x_den)
  );

  amt_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (x_valid),
    .in_tag    (x_tag),
    .num       (x_num),
    .neg       (x_neg),
    .den       (x_den),
    .out_valid (d_valid),
    .out_tag   (d_tag),
    .quo       (d_quo),
    .ovf       (d_ovf),
    .qneg      (d_neg)
  );

  amt_reduce #(.COORD_BITS(COORD_BITS)) u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_tag    (d_tag),
    .quo       (d_quo),
    .ovf       (d_ovf),
    .qneg      (d_neg),
    .res_valid (out_res.valid),
    .res_ready (out_res.ready),
    .res_data  (out_res.data)
  );

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> corner_r == 3'd7)
    else $error("box left the queue before its last corner");

  a_idle_corner: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> corner_r == 3'd0)
    else $error("corner count not at zero with the queue empty");

  a_stall_keeps_head: assert property (@(posedge clk) disable iff (!rst_n)
    !en && q_valid |=> q_valid && $stable(corner_r))
    else $error("queue head moved during a stall");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the transformed bounding box core, with its own arithmetic model.
module tb;

  localparam logic [amt_pkg::CFG_IDX_W-1:0] IDX_UNUSED_LO = 4'd8;
  localparam logic [amt_pkg::CFG_IDX_W-1:0] IDX_UNUSED_HI = 4'd15;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam logic [31:0] CMAX  = 32'h7fff_ffff;
  localparam logic [31:0] CMIN  = 32'h8000_0000;
  localparam int SETTLE = 60;
  localparam int FRAC_W = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [amt_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [amt_pkg::CFG_W-1:0] cfg_wdata = '0;

  amt_box_if box_ch ();
  amt_res_if res_ch ();

  aabb_matrix_transform_core dut (
    .clk(clk), .rst_n(rst_n), .in_box(box_ch), .out_res(res_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  logic [63:0] mat_regs [amt_pkg::NUM_REGS];
  amt_pkg::res_t expected_bounds [$];
  int mismatches = 0;
  int burst_left = 1;
  int stall_mode = 0;
  int stall_count = 0;

  initial begin
    box_ch.valid = 1'b0;
    box_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  function automatic logic signed [127:0] entry(int row, int col);
    logic [63:0] r;
    logic signed [31:0] h;
    r = mat_regs[row * 2 + col / 2];
    h = (col % 2) ? r[63:32] : r[31:0];
    return h;
  endfunction

  function automatic logic [31:0] sat_quot(logic signed [127:0] num, logic signed [127:0] w);
    logic signed [127:0] q;
    q = (num <<< FRAC_W) / w;
    if (q > $signed(128'(CMAX))) return CMAX;
    if (q < -$signed(128'h8000_0000)) return CMIN;
    return q[31:0];
  endfunction

  function automatic amt_pkg::res_t transform_box(amt_pkg::box_t b);
    amt_pkg::res_t r;
    logic signed [127:0] lo [3];
    logic signed [127:0] hi [3];
    logic signed [127:0] p [3];
    logic signed [127:0] acc [4];
    logic signed [31:0] v [3];
    logic signed [31:0] mn [3];
    logic signed [31:0] mx [3];
    logic any;
    logic fault;
    lo[0] = b.in_min_x; lo[1] = b.in_min_y; lo[2] = b.in_min_z;
    hi[0] = b.in_max_x; hi[1] = b.in_max_y; hi[2] = b.in_max_z;
    any = 1'b0;
    fault = 1'b0;
    for (int j = 0; j < 3; j++) begin
      mn[j] = 0;
      mx[j] = 0;
    end
    for (int c = 0; c < 8; c++) begin
      for (int j = 0; j < 3; j++) p[j] = ((c >> j) & 1) ? hi[j] : lo[j];
      for (int j = 0; j < 4; j++) begin
        acc[j] = entry(3, j) <<< FRAC_W;
        for (int k = 0; k < 3; k++) acc[j] = acc[j] + p[k] * entry(k, j);
      end
      if (acc[3] == 0) begin
        fault = 1'b1;
      end else begin
        for (int j = 0; j < 3; j++) begin
          v[j] = sat_quot(acc[j], acc[3]);
          if (!any || v[j] < mn[j]) mn[j] = v[j];
          if (!any || v[j] > mx[j]) mx[j] = v[j];
        end
        any = 1'b1;
      end
    end
    r.out_min_x = mn[0]; r.out_min_y = mn[1]; r.out_min_z = mn[2];
    r.out_max_x = mx[0]; r.out_max_y = mx[1]; r.out_max_z = mx[2];
    r.divide_fault = fault;
    return r;
  endfunction

  // Result side: check each accepted beat, then choose the next ready level.
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_bounds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", res_ch.data);
      end else begin
        amt_pkg::res_t e;
        e = expected_bounds.pop_front();
        if (res_ch.data !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", e, res_ch.data);
        end
      end
    end
    if (stall_count == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_count = $urandom_range(20, 300);
    end
    stall_count--;
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= ($urandom_range(0, 3) != 0);
      2: res_ch.ready <= ($urandom_range(0, 1) != 0);
      default: res_ch.ready <= (stall_count % 16) < 4;
    endcase
  end

  task automatic send_box(amt_pkg::box_t b);
    box_ch.valid <= 1'b1;
    box_ch.data <= b;
    do @(posedge clk); while (!box_ch.ready);
    expected_bounds = {expected_bounds, transform_box(b)};
    if (--burst_left == 0) begin
      box_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 30);
    end
  endtask

  task automatic drain;
    box_ch.valid <= 1'b0;
    while (expected_bounds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes happen only with the pipeline empty; unused indexes leave the matrix alone.
  task automatic write_reg(logic [amt_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < amt_pkg::NUM_REGS) mat_regs[idx[2:0]] = val;
    @(posedge clk);
  endtask

  task automatic load_identity;
    write_reg(amt_pkg::REG_R1_C12, {32'h0, ONE_Q});
    write_reg(amt_pkg::REG_R1_C34, 64'h0);
    write_reg(amt_pkg::REG_R2_C12, {ONE_Q, 32'h0});
    write_reg(amt_pkg::REG_R2_C34, 64'h0);
    write_reg(amt_pkg::REG_R3_C12, 64'h0);
    write_reg(amt_pkg::REG_R3_C34, {32'h0, ONE_Q});
    write_reg(amt_pkg::REG_R4_C12, 64'h0);
    write_reg(amt_pkg::REG_R4_C34, {ONE_Q, 32'h0});
  endtask

  function automatic logic [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: case ($urandom_range(0, 3))
        0: return CMIN;
        1: return CMAX;
        2: return 32'h0;
        default: return 32'hffff_ffff;
      endcase
    endcase
  endfunction

  function automatic amt_pkg::box_t rand_box();
    amt_pkg::box_t b;
    int kind;
    kind = $urandom_range(0, 9);
    kind = (kind < 3) ? 0 : (kind < 9) ? 1 : 2;
    b = {rand_coord(kind), rand_coord(kind), rand_coord(kind),
         rand_coord(kind), rand_coord(kind), rand_coord(kind)};
    return b;
  endfunction

  function automatic logic [31:0] rand_entry(int kind);
    case (kind)
      0: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      1: return $urandom;
      default: case ($urandom_range(0, 3))
        0: return CMIN;
        1: return CMAX;
        2: return 32'h0;
        default: return ONE_Q;
      endcase
    endcase
  endfunction

  task automatic test_reset_identity;
    mat_regs[0] = {32'h0, ONE_Q}; mat_regs[1] = 64'h0;
    mat_regs[2] = {ONE_Q, 32'h0}; mat_regs[3] = 64'h0;
    mat_regs[4] = 64'h0; mat_regs[5] = {32'h0, ONE_Q};
    mat_regs[6] = 64'h0; mat_regs[7] = {ONE_Q, 32'h0};
    send_box({CMIN, CMIN, CMIN, CMAX, CMAX, CMAX});
    send_box({CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
    send_box('0);
    send_box({6{32'hffff_ffff}});
    send_box({32'h0003_8000, 32'hfffe_0000, 32'h0, 32'hffff_0000, 32'h0002_0000, 32'h0001_0000});
    drain();
  endtask

  task automatic test_saturation;
    write_reg(amt_pkg::REG_R1_C12, {32'h0, 32'h0004_0000});
    write_reg(amt_pkg::REG_R2_C12, {32'hfffc_0000, 32'h0});
    write_reg(amt_pkg::REG_R4_C12, {CMIN, CMAX});
    send_box({CMIN, CMIN, CMIN, CMAX, CMAX, CMAX});
    send_box({32'h1000_0000, 32'hf000_0000, 32'h0, 32'h2000_0000, 32'h0100_0000, 32'h0});
    drain();
    write_reg(amt_pkg::REG_R4_C34, {32'h0000_0001, 32'h0});
    send_box({32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h2});
    send_box({CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
    drain();
    load_identity();
  endtask

  task automatic test_zero_w;
    // w follows z alone, so corners on the z = 0 plane are dropped.
    write_reg(amt_pkg::REG_R3_C34, {ONE_Q, ONE_Q});
    write_reg(amt_pkg::REG_R4_C34, 64'h0);
    send_box({32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000});
    send_box({32'hffff_0000, 32'h0, 32'hfffb_0000, 32'h0001_0000, 32'h0002_0000, 32'h0});
    drain();
    // All w columns zero: no corner survives.
    write_reg(amt_pkg::REG_R1_C34, 64'h0);
    write_reg(amt_pkg::REG_R2_C34, 64'h0);
    write_reg(amt_pkg::REG_R3_C34, {32'h0, ONE_Q});
    send_box({CMIN, CMIN, CMIN, CMAX, CMAX, CMAX});
    send_box({32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000, 32'h0, 32'h0});
    drain();
    load_identity();
  endtask

  task automatic test_unused_index;
    write_reg(IDX_UNUSED_LO, {CMAX, CMAX});
    write_reg(IDX_UNUSED_HI, 64'h0);
    write_reg(IDX_UNUSED_LO + 4'($urandom_range(0, 7)), {$urandom, $urandom});
    send_box({32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              32'h0004_0000, 32'h0005_0000, 32'h0006_0000});
    drain();
  endtask

  task automatic test_random_matrices(int phases, int per_phase);
    int kind;
    for (int ph = 0; ph < phases; ph++) begin
      kind = ph % 4;
      for (int k = 0; k < amt_pkg::NUM_REGS; k++) begin
        if (kind == 0 && (k == 1 || k == 3 || k == 5))
          write_reg(k[3:0], {32'h0, rand_entry(0)});
        else if (kind == 0 && k == 7)
          write_reg(k[3:0], {ONE_Q, rand_entry(0)});
        else
          write_reg(k[3:0], {rand_entry(kind == 3 ? $urandom_range(0, 2) : kind % 3),
                             rand_entry(kind == 3 ? $urandom_range(0, 2) : kind % 3)});
      end
      for (int i = 0; i < per_phase; i++) send_box(rand_box());
      drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_identity();
    test_saturation();
    test_zero_w();
    test_unused_index();
    test_random_matrices(8, 240);
    if (mismatches == 0 && expected_bounds.size() == 0) begin
      $display("aabb_matrix_transform_core test passed");
    end else begin
      $display("aabb_matrix_transform_core test failed");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("aabb_matrix_transform_core test failed");
    $finish;
  end

endmodule
